// ----- rtl/date_string_validator_macros.svh -----
// Assertion helpers for the date string validator.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef DATE_STRING_VALIDATOR_MACROS_SVH
`define DATE_STRING_VALIDATOR_MACROS_SVH

// Same-cycle implication.
`define DSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define DSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/dsv_pkg.sv -----
package dsv_pkg;

  // Verdict codes on the status port
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DASH      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NONDIGIT  = 3'd3,
    ST_BAD_MONTH = 3'd4,
    ST_BAD_DAY   = 3'd5
  } status_t;

  localparam logic [7:0] DASH_CHAR  = 8'h2D;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [3:0] MONTH_SAT  = 4'd13;
  localparam logic [5:0] DAY_SAT    = 6'd32;
  localparam logic [4:0] LEAP_FEB   = 5'd29;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [1:0] DASH_SAT   = 2'd3;
  localparam logic [1:0] DASH_GOOD  = 2'd2;
  localparam int unsigned YEAR_CYCLE = 400;
  // floor(v * YEAR_RECIP / 2^YEAR_SHIFT) undershoots v / 400 by at most one
  localparam logic [9:0]  YEAR_RECIP = 10'd655;
  localparam int unsigned YEAR_SHIFT = 18;

  typedef struct packed {
    logic [1:0] dash_count;
    logic [8:0] year_mod;
    logic [3:0] month_accum;
    logic [5:0] day_accum;
    logic [2:0] field_nonempty;
    logic [2:0] field_nondigit;
  } parse_state_t;

  // Days in a common year; codes outside 1..12 give zero
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    begin
      case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                   days = 5'd30;
        4'd2:                                       days = 5'd28;
        default:                                    days = 5'd0;
      endcase
      return days;
    end
  endfunction

endpackage

// ----- rtl/date_string_validator.sv -----
// Date string validator: checks a year-month-day string, one character per word.
// Input channel: char_code and is_last with in_valid/in_ready. Output channel:
// status, month_value, day_value and leap_flag with out_valid/out_ready; one
// result word per string, issued for the word that carries is_last.
// The last character passes the input register, then the result register.
// Throughput: one character per cycle unless the receiver stalls, set by the input
// register feeding the per-character update and verdict logic that loads the result
// register. Characters that are not last update the parse state and give no result.
// When the receiver stalls, the result register holds and so does the input
// register; once a character waits there, in_ready drops until the result
// is taken.
// Reset clears the parse state and both valid flags; no word is in flight.
// After each result the parse state returns to empty for the next string.
`include "date_string_validator_macros.svh"

module date_string_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [3:0] month_value,
  output logic [5:0] day_value,
  output logic       leap_flag
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_char;
  logic       in_last;

  dsv_pkg::parse_state_t pstate;
  dsv_pkg::parse_state_t pstate_next;
  dsv_pkg::parse_state_t upd;

  logic advance;
  logic fire;

  logic        is_dash;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] year_lin;
  logic [21:0] year_prod;
  logic [3:0]  year_quot;
  logic [11:0] year_rem;
  logic [7:0]  month_lin;
  logic [8:0]  day_lin;

  logic            leap;
  logic [4:0]      day_limit;
  dsv_pkg::status_t verdict;

  assign advance  = !out_valid || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // Hold or load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_code;
      in_last <= is_last;
    end
  end

  // Classify the character
  assign is_dash  = (in_char == dsv_pkg::DASH_CHAR);
  assign is_digit = (in_char >= dsv_pkg::DIGIT_LO) && (in_char <= dsv_pkg::DIGIT_HI);
  assign digit    = 4'(in_char - dsv_pkg::DIGIT_LO);

  // Year times ten plus digit, reduced mod 400 by reciprocal and one correction
  assign year_lin  = {pstate.year_mod, 3'b000} + {2'b00, pstate.year_mod, 1'b0}
                   + {8'd0, digit};
  assign year_prod = 22'(year_lin) * 22'(dsv_pkg::YEAR_RECIP);
  assign year_quot = year_prod[dsv_pkg::YEAR_SHIFT +: 4];

  always_comb begin
    year_rem = year_lin - 12'(year_quot * 12'(dsv_pkg::YEAR_CYCLE));
    if (year_rem >= 12'(dsv_pkg::YEAR_CYCLE)) begin
      year_rem = year_rem - 12'(dsv_pkg::YEAR_CYCLE);
    end
  end

  assign month_lin = {pstate.month_accum, 3'b000} + {3'b000, pstate.month_accum, 1'b0}
                   + {4'd0, digit};
  assign day_lin   = {pstate.day_accum, 3'b000} + {2'b00, pstate.day_accum, 1'b0}
                   + {5'd0, digit};

  // Apply one character to the parse state
  always_comb begin
    upd = pstate;
    if (is_dash) begin
      if (pstate.dash_count != dsv_pkg::DASH_SAT) begin
        upd.dash_count = pstate.dash_count + 2'd1;
      end
    end else if (pstate.dash_count != dsv_pkg::DASH_SAT) begin
      upd.field_nonempty[pstate.dash_count] = 1'b1;
      if (is_digit) begin
        case (pstate.dash_count)
          2'd0: upd.year_mod = year_rem[8:0];
          2'd1: upd.month_accum = (month_lin > 8'(dsv_pkg::MONTH_SAT))
                                ? dsv_pkg::MONTH_SAT : month_lin[3:0];
          default: upd.day_accum = (day_lin > 9'(dsv_pkg::DAY_SAT))
                                 ? dsv_pkg::DAY_SAT : day_lin[5:0];
        endcase
      end else begin
        upd.field_nondigit[pstate.dash_count] = 1'b1;
      end
    end
  end

  // Gregorian leap rule on the year mod 400
  assign leap = (upd.year_mod[1:0] == 2'b00) && (upd.year_mod != 9'd100)
             && (upd.year_mod != 9'd200) && (upd.year_mod != 9'd300);

  always_comb begin
    day_limit = dsv_pkg::month_days(upd.month_accum);
    if ((upd.month_accum == dsv_pkg::MONTH_FEB) && leap) begin
      day_limit = dsv_pkg::LEAP_FEB;
    end
  end

  // First failing check sets the verdict
  always_comb begin
    if (upd.dash_count != dsv_pkg::DASH_GOOD) begin
      verdict = dsv_pkg::ST_DASH;
    end else if (!upd.field_nonempty[0]) begin
      verdict = dsv_pkg::ST_EMPTY;
    end else if (upd.field_nondigit[0]) begin
      verdict = dsv_pkg::ST_NONDIGIT;
    end else if (!upd.field_nonempty[1]) begin
      verdict = dsv_pkg::ST_EMPTY;
    end else if (upd.field_nondigit[1]) begin
      verdict = dsv_pkg::ST_NONDIGIT;
    end else if ((upd.month_accum == 4'd0) || (upd.month_accum > dsv_pkg::MONTH_MAX)) begin
      verdict = dsv_pkg::ST_BAD_MONTH;
    end else if (!upd.field_nonempty[2]) begin
      verdict = dsv_pkg::ST_EMPTY;
    end else if (upd.field_nondigit[2]) begin
      verdict = dsv_pkg::ST_NONDIGIT;
    end else if ((upd.day_accum == 6'd0) || (upd.day_accum > {1'b0, day_limit})) begin
      verdict = dsv_pkg::ST_BAD_DAY;
    end else begin
      verdict = dsv_pkg::ST_OK;
    end
  end

  // Advance the parse state; drop it after the last character
  always_comb begin
    pstate_next = pstate;
    if (fire) begin
      pstate_next = in_last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= '0;
    end else begin
      pstate <= pstate_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      status      <= verdict;
      month_value <= upd.month_accum;
      day_value   <= upd.day_accum;
      leap_flag   <= leap;
    end
  end

  // Checks
  `DSV_ASSERT_IMP(a_ok_in_range, out_valid && (status == dsv_pkg::ST_OK),
    (month_value != 4'd0) && (month_value <= dsv_pkg::MONTH_MAX) &&
    (day_value != 6'd0) && (day_value <= 6'd31))
  `DSV_ASSERT_NXT(a_clear_after_last, fire && in_last,
    (pstate.dash_count == 2'd0) && (pstate.field_nonempty == 3'd0) &&
    (pstate.field_nondigit == 3'd0))
  `DSV_ASSERT_IMP(a_stall_cause, !in_ready,
    in_valid_r && out_valid && !out_ready)
  `DSV_ASSERT_IMP(a_year_range, 1'b1,
    pstate.year_mod < 9'(dsv_pkg::YEAR_CYCLE))

endmodule

// ----- sim/tb.sv -----
module tb;

  typedef struct packed {
    dsv_pkg::status_t st;
    logic [3:0]       mo;
    logic [5:0]       dy;
    logic             lp;
  } verdict_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    verdict_t   v;
  } char_row_t;

  localparam int unsigned RANDOM_CHARS = 1550;
  localparam int unsigned STEADY_LO    = 600;
  localparam int unsigned STEADY_HI    = 950;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [3:0] month_value;
  logic [5:0] day_value;
  logic       leap_flag;

  // typed expectation that travels with the word on the input channel
  logic       cur_typed;
  verdict_t   cur_verdict;

  char_row_t   rows[$];
  logic [7:0]  txt[$];
  verdict_t    verdict_q[$];
  int unsigned bad_words;
  bit          steady;

  // predictor state for the string being parsed
  int unsigned dashes;
  int unsigned year_mod;
  int unsigned month_acc;
  int unsigned day_acc;
  logic [2:0]  seen;
  logic [2:0]  non_digit;

  int unsigned days_in_month[0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  date_string_validator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .month_value(month_value),
    .day_value  (day_value),
    .leap_flag  (leap_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  function automatic dsv_pkg::status_t field_code(input int unsigned k);
    if (!seen[k]) return dsv_pkg::ST_EMPTY;
    if (non_digit[k]) return dsv_pkg::ST_NONDIGIT;
    return dsv_pkg::ST_OK;
  endfunction

  // Update the parse state with one character; on the last one, form the verdict and clear
  task automatic parse_char(input logic [7:0] ch, input logic last,
                            output bit done, output verdict_t v);
    int unsigned k;
    int unsigned d;
    int unsigned lim;
    logic        leap;
    done = 1'b0;
    v    = '0;
    if (ch == dsv_pkg::DASH_CHAR) begin
      if (dashes < dsv_pkg::DASH_SAT) dashes++;
    end else if (dashes < dsv_pkg::DASH_SAT) begin
      k = dashes;
      seen[k] = 1'b1;
      if (ch >= dsv_pkg::DIGIT_LO && ch <= dsv_pkg::DIGIT_HI) begin
        d = ch - dsv_pkg::DIGIT_LO;
        case (k)
          0: year_mod = (year_mod * 10 + d) % dsv_pkg::YEAR_CYCLE;
          1: begin
            month_acc = month_acc * 10 + d;
            if (month_acc > dsv_pkg::MONTH_SAT) month_acc = dsv_pkg::MONTH_SAT;
          end
          default: begin
            day_acc = day_acc * 10 + d;
            if (day_acc > dsv_pkg::DAY_SAT) day_acc = dsv_pkg::DAY_SAT;
          end
        endcase
      end else begin
        non_digit[k] = 1'b1;
      end
    end
    if (!last) return;

    leap = ((year_mod % 4 == 0) && (year_mod % 100 != 0)) || (year_mod == 0);
    v.st = dsv_pkg::ST_OK;
    if (dashes != dsv_pkg::DASH_GOOD) begin
      v.st = dsv_pkg::ST_DASH;
    end else if (field_code(0) != dsv_pkg::ST_OK) begin
      v.st = field_code(0);
    end else if (field_code(1) != dsv_pkg::ST_OK) begin
      v.st = field_code(1);
    end else if (month_acc == 0 || month_acc > dsv_pkg::MONTH_MAX) begin
      v.st = dsv_pkg::ST_BAD_MONTH;
    end else if (field_code(2) != dsv_pkg::ST_OK) begin
      v.st = field_code(2);
    end else begin
      lim = days_in_month[month_acc];
      if (month_acc == dsv_pkg::MONTH_FEB && leap) lim = dsv_pkg::LEAP_FEB;
      if (day_acc == 0 || day_acc > lim) v.st = dsv_pkg::ST_BAD_DAY;
    end
    v.mo = month_acc[3:0];
    v.dy = day_acc[5:0];
    v.lp = leap;
    done = 1'b1;

    // start the next string from empty
    dashes    = 0;
    year_mod  = 0;
    month_acc = 0;
    day_acc   = 0;
    seen      = '0;
    non_digit = '0;
  endtask

  task automatic add_char(input logic [7:0] ch, input logic last);
    rows.push_back('{ch: ch, last: last, typed: 1'b0, v: '0});
  endtask

  task automatic add_end(input logic [7:0] ch, input dsv_pkg::status_t st,
                         input logic [3:0] mo, input logic [5:0] dy, input logic lp);
    verdict_t v;
    v.st = st;
    v.mo = mo;
    v.dy = dy;
    v.lp = lp;
    rows.push_back('{ch: ch, last: 1'b1, typed: 1'b1, v: v});
  endtask

  // Append n in decimal, zero padded to at least w digits
  task automatic put_num(input int unsigned n, input int w);
    int i;
    while (w < 9 && 10 ** w <= n) w++;
    for (i = w - 1; i >= 0; i--)
      txt.push_back(dsv_pkg::DIGIT_LO + 8'((n / (10 ** i)) % 10));
  endtask

  // Build one random string into txt: mostly well-formed dates, some broken, some noise
  task automatic make_string();
    int unsigned kind;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int          yw;
    int unsigned pos;
    int unsigned keep;
    txt.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 10))
        txt.push_back(($urandom_range(9) < 3) ? dsv_pkg::DASH_CHAR : 8'($urandom_range(255)));
      return;
    end
    yw = $urandom_range(1, 6);
    yr = $urandom % (10 ** yw);
    case ($urandom_range(3))
      0: yr = yr - yr % 100;
      1: yr = yr - yr % 4;
      default: ;
    endcase
    mo = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    if (mo >= 1 && mo <= 12 && $urandom_range(2) == 0)
      dy = days_in_month[mo] + $urandom_range(0, 1);
    else if ($urandom_range(9) < 8)
      dy = $urandom_range(1, 31);
    else
      dy = $urandom_range(0, 99);
    put_num(yr, yw);
    txt.push_back(dsv_pkg::DASH_CHAR);
    put_num(mo, $urandom_range(1, 2));
    txt.push_back(dsv_pkg::DASH_CHAR);
    put_num(dy, $urandom_range(1, 2));
    if (kind < 35) begin
      pos = $urandom_range(txt.size() - 1);
      case ($urandom_range(3))
        0: txt[pos] = 8'($urandom_range(255));
        1: txt.insert(pos, dsv_pkg::DASH_CHAR);
        2: if (txt.size() > 1) txt.delete(pos);
        default: begin
          keep = $urandom_range(1, txt.size());
          while (txt.size() > keep) void'(txt.pop_back());
        end
      endcase
    end
  endtask

  // Stimulus: directed table, then random strings
  initial begin
    int unsigned idx;
    int unsigned dir_count;
    int unsigned i;
    int unsigned waited;

    rst         = 1'b1;
    in_valid    = 1'b0;
    char_code   = '0;
    is_last     = 1'b0;
    cur_typed   = 1'b0;
    cur_verdict = '0;
    steady      = 1'b0;
    bad_words   = 0;
    dashes      = 0;
    year_mod    = 0;
    month_acc   = 0;
    day_acc     = 0;
    seen        = '0;
    non_digit   = '0;

    // lone dash
    add_end(dsv_pkg::DASH_CHAR, dsv_pkg::ST_DASH, 4'd0, 6'd0, 1'b1);
    // two dashes, every field empty
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_end(dsv_pkg::DASH_CHAR, dsv_pkg::ST_EMPTY, 4'd0, 6'd0, 1'b1);
    // top byte in the year
    add_char(8'hFF, 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char("1", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_end("1", dsv_pkg::ST_NONDIGIT, 4'd1, 6'd1, 1'b1);
    // month saturates
    add_char("1", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char("9", 1'b0);
    add_char("9", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_end("1", dsv_pkg::ST_BAD_MONTH, 4'd13, 6'd1, 1'b0);
    // leap day in a year divisible by 400
    add_char("0", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char("2", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char("2", 1'b0);
    add_end("9", dsv_pkg::ST_OK, 4'd2, 6'd29, 1'b1);
    // third dash, later characters ignored
    add_char("1", 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_char(dsv_pkg::DASH_CHAR, 1'b0);
    add_end(8'h80, dsv_pkg::ST_DASH, 4'd0, 6'd0, 1'b0);
    dir_count = rows.size();

    while (rows.size() < dir_count + RANDOM_CHARS) begin
      make_string();
      for (i = 0; i < txt.size(); i++) add_char(txt[i], i == txt.size() - 1);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < rows.size(); idx++) begin
      steady = (idx >= STEADY_LO && idx < STEADY_HI);
      // hold off until the directed strings have fully drained
      if (idx == dir_count) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
      end
      while (!steady && $urandom_range(99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid    <= 1'b1;
      char_code   <= rows[idx].ch;
      is_last     <= rows[idx].last;
      cur_typed   <= rows[idx].typed;
      cur_verdict <= rows[idx].v;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    @(posedge clk);
    waited = 0;
    while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_words == 0 && verdict_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Predict on accepted input words, check accepted result words
  bit       produced;
  verdict_t predicted;
  verdict_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 17);

      if (in_valid && in_ready) begin
        parse_char(char_code, is_last, produced, predicted);
        if (produced) verdict_q.push_back(cur_typed ? cur_verdict : predicted);
      end

      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected result: st=%0d mo=%0d dy=%0d lp=%0d",
                     status, month_value, day_value, leap_flag);
        end else begin
          want = verdict_q.pop_front();
          if (status !== want.st || month_value !== want.mo ||
              day_value !== want.dy || leap_flag !== want.lp) begin
            bad_words++;
            if (bad_words <= 10)
              $display({"mismatch: exp st=%0d mo=%0d dy=%0d lp=%0d, ",
                        "got st=%0d mo=%0d dy=%0d lp=%0d"},
                       want.st, want.mo, want.dy, want.lp,
                       status, month_value, day_value, leap_flag);
          end
        end
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dsv_pkg.sv
rtl/date_string_validator.sv
sim/tb.sv
